### rtl/first_fit_heap_allocator_core_assert.svh
// Assertion macros for the first-fit heap allocator core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication: whenever ante holds, cons must hold
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator core.
// No dependencies; used by first_fit_heap_allocator_core.
package ffha_pkg;

    localparam int ARENA_BYTES_DEF = 65536;
    localparam int GRAN_BYTES      = 8;
    localparam int GRAN_SHIFT      = $clog2(GRAN_BYTES);
    localparam int REQ_W           = 16;
    // Width of the request size in granules after rounding up
    localparam int REQ_GRAN_W      = REQ_W + 1 - GRAN_SHIFT;
    // Width of the granule index of a header derived from a payload offset
    localparam int TGT_W           = REQ_W - GRAN_SHIFT;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_ALLOC   = 3'd0,
        STAT_ZERO    = 3'd1,
        STAT_NOSPACE = 3'd2,
        STAT_FREED   = 3'd3,
        STAT_NULL    = 3'd4,
        STAT_REJECT  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_F_RD,
        ST_F_CHK,
        ST_M_RD,
        ST_M_LD,
        ST_M_CHK
    } t_state;

    typedef struct packed {
        logic             kind;
        logic [REQ_W-1:0] request_size;
        logic [REQ_W-1:0] payload_offset;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [REQ_W-1:0] block_offset;
        logic [REQ_W-1:0] free_bytes;
    } t_out_item;

endpackage

### rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator: header walk over the arena with one shared step adder.
// Zero-size and null/unaligned requests give their result in the cycle after start;
// otherwise one memory read per header visited, plus a merge pass over the whole block
// list after every successful free. One item at a time: busy is high until a walk's
// result strobe, low for an item answered at once. Reset is synchronous; the cycle after
// it writes the first header, busy high. Receiver cannot stall: o_valid lasts one cycle.
`include "first_fit_heap_allocator_core_assert.svh"

module first_fit_heap_allocator_core #(
    parameter int ARENA_BYTES = ffha_pkg::ARENA_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffha_pkg::t_in_item   i_item,
    output logic                 o_valid,
    output ffha_pkg::t_out_item  o_result
);

    localparam int GRANULES = ARENA_BYTES / ffha_pkg::GRAN_BYTES;
    localparam int AW       = $clog2(GRANULES);
    localparam int GW       = AW + 1;
    localparam int CW       = ((AW > ffha_pkg::REQ_GRAN_W) ? AW : ffha_pkg::REQ_GRAN_W) + 2;
    localparam int OW       = ((AW + ffha_pkg::GRAN_SHIFT + 1) > ffha_pkg::REQ_W) ?
                              (AW + ffha_pkg::GRAN_SHIFT + 1) : ffha_pkg::REQ_W;
    localparam int FBW      = ((AW + ffha_pkg::GRAN_SHIFT) > ffha_pkg::REQ_W) ?
                              (AW + ffha_pkg::GRAN_SHIFT) : ffha_pkg::REQ_W;

    // Header store: free mark on top, payload size in granules below
    logic [AW:0]                   r_mem [GRANULES];
    logic [AW:0]                   r_rdata;

    ffha_pkg::t_state              r_state, n_state;
    logic [GW-1:0]                 r_g, n_g;
    logic [GW-1:0]                 r_nx, n_nx;
    logic [ffha_pkg::REQ_GRAN_W-1:0] r_szg, n_szg;
    logic [ffha_pkg::TGT_W-1:0]    r_tgt, n_tgt;
    logic [AW-1:0]                 r_bs, n_bs;
    logic [AW-1:0]                 r_cs, n_cs;
    logic [AW-1:0]                 r_free, n_free;
    logic                          r_valid, n_valid;
    ffha_pkg::t_status             r_status, n_status;
    logic [ffha_pkg::REQ_W-1:0]    r_boff, n_boff;

    logic                          rd_en, wr_en;
    logic [AW-1:0]                 rd_addr, wr_addr;
    logic [AW:0]                   wr_data;

    logic                          rd_free;
    logic [AW-1:0]                 rd_size;
    logic [GW-1:0]                 step_base, step;
    logic                          step_end;
    logic [AW-1:0]                 merged;
    logic [ffha_pkg::REQ_W:0]      req_sum;
    logic [OW-1:0]                 boff_w;
    logic [FBW-1:0]                fb_w;
    logic                          g_end;

    assign rd_free = r_rdata[AW];
    assign rd_size = r_rdata[AW-1:0];

    // Shared step unit: next block start = base + 1 + size just read
    assign step_base = (r_state == ffha_pkg::ST_M_CHK) ? r_nx : r_g;
    assign step      = step_base + GW'(1) + GW'(rd_size);
    assign step_end  = CW'(step) >= CW'(GRANULES);
    assign g_end     = CW'(r_g) >= CW'(GRANULES);
    assign merged    = r_cs + AW'(1) + rd_size;

    assign req_sum = {1'b0, i_item.request_size} + (ffha_pkg::REQ_W+1)'(ffha_pkg::GRAN_BYTES - 1);
    assign boff_w  = (OW'(r_g) + OW'(1)) << ffha_pkg::GRAN_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::ST_INIT;
            r_valid <= 1'b0;
            r_free  <= AW'(GRANULES - 1);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g      <= n_g;
        r_nx     <= n_nx;
        r_szg    <= n_szg;
        r_tgt    <= n_tgt;
        r_bs     <= n_bs;
        r_cs     <= n_cs;
        r_status <= n_status;
        r_boff   <= n_boff;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_g      = r_g;
        n_nx     = r_nx;
        n_szg    = r_szg;
        n_tgt    = r_tgt;
        n_bs     = r_bs;
        n_cs     = r_cs;
        n_free   = r_free;
        n_valid  = 1'b0;
        n_status = r_status;
        n_boff   = r_boff;
        rd_en    = 1'b0;
        rd_addr  = r_g[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_g[AW-1:0];
        wr_data  = '0;

        unique case (r_state)
            ffha_pkg::ST_INIT: begin
                // One free block covering the arena
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b1, AW'(GRANULES - 1)};
                n_state = ffha_pkg::ST_IDLE;
            end

            ffha_pkg::ST_IDLE: begin
                if (start) begin
                    n_boff = '0;
                    n_g    = '0;
                    if (i_item.kind == ffha_pkg::KIND_ALLOC) begin
                        if (i_item.request_size == '0) begin
                            n_valid  = 1'b1;
                            n_status = ffha_pkg::STAT_ZERO;
                        end else begin
                            n_szg   = req_sum[ffha_pkg::REQ_W:ffha_pkg::GRAN_SHIFT];
                            n_state = ffha_pkg::ST_A_RD;
                        end
                    end else if (i_item.payload_offset == '0) begin
                        n_valid  = 1'b1;
                        n_status = ffha_pkg::STAT_NULL;
                    end else if (i_item.payload_offset[ffha_pkg::GRAN_SHIFT-1:0] != '0 ||
                                 i_item.payload_offset[ffha_pkg::REQ_W-1:ffha_pkg::GRAN_SHIFT]
                                 == '0) begin
                        n_valid  = 1'b1;
                        n_status = ffha_pkg::STAT_REJECT;
                    end else begin
                        n_tgt   = i_item.payload_offset[ffha_pkg::REQ_W-1:ffha_pkg::GRAN_SHIFT]
                                  - ffha_pkg::TGT_W'(1);
                        n_state = ffha_pkg::ST_F_RD;
                    end
                end
            end

            ffha_pkg::ST_A_RD: begin
                if (g_end) begin
                    n_valid  = 1'b1;
                    n_status = ffha_pkg::STAT_NOSPACE;
                    n_state  = ffha_pkg::ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = ffha_pkg::ST_A_CHK;
                end
            end

            ffha_pkg::ST_A_CHK: begin
                if (rd_free && CW'(rd_size) >= CW'(r_szg)) begin
                    wr_en = 1'b1;
                    if (CW'(rd_size) >= CW'(r_szg) + CW'(2)) begin
                        // Split: the tail becomes a new free block
                        wr_data = {1'b0, AW'(r_szg)};
                        n_free  = r_free - AW'(r_szg) - AW'(1);
                        n_bs    = rd_size;
                        n_state = ffha_pkg::ST_A_SPLIT;
                    end else begin
                        wr_data  = {1'b0, rd_size};
                        n_free   = r_free - rd_size;
                        n_valid  = 1'b1;
                        n_status = ffha_pkg::STAT_ALLOC;
                        n_boff   = boff_w[ffha_pkg::REQ_W-1:0];
                        n_state  = ffha_pkg::ST_IDLE;
                    end
                end else begin
                    n_g     = step;
                    n_state = ffha_pkg::ST_A_RD;
                end
            end

            ffha_pkg::ST_A_SPLIT: begin
                wr_en    = 1'b1;
                wr_addr  = AW'(r_g + GW'(1) + GW'(r_szg));
                wr_data  = {1'b1, r_bs - AW'(r_szg) - AW'(1)};
                n_valid  = 1'b1;
                n_status = ffha_pkg::STAT_ALLOC;
                n_boff   = boff_w[ffha_pkg::REQ_W-1:0];
                n_state  = ffha_pkg::ST_IDLE;
            end

            ffha_pkg::ST_F_RD: begin
                if (g_end) begin
                    n_valid  = 1'b1;
                    n_status = ffha_pkg::STAT_REJECT;
                    n_state  = ffha_pkg::ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = ffha_pkg::ST_F_CHK;
                end
            end

            ffha_pkg::ST_F_CHK: begin
                if (CW'(r_g) < CW'(r_tgt)) begin
                    n_g     = step;
                    n_state = ffha_pkg::ST_F_RD;
                end else if (CW'(r_g) != CW'(r_tgt) || rd_free) begin
                    n_valid  = 1'b1;
                    n_status = ffha_pkg::STAT_REJECT;
                    n_state  = ffha_pkg::ST_IDLE;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, rd_size};
                    n_free  = r_free + rd_size;
                    n_g     = '0;
                    n_state = ffha_pkg::ST_M_RD;
                end
            end

            ffha_pkg::ST_M_RD: begin
                rd_en   = 1'b1;
                n_state = ffha_pkg::ST_M_LD;
            end

            ffha_pkg::ST_M_LD: begin
                n_cs = rd_size;
                if (step_end) begin
                    n_valid  = 1'b1;
                    n_status = ffha_pkg::STAT_FREED;
                    n_state  = ffha_pkg::ST_IDLE;
                end else if (!rd_free) begin
                    n_g     = step;
                    n_state = ffha_pkg::ST_M_RD;
                end else begin
                    // Fetch the neighbour of a free block
                    n_nx    = step;
                    rd_en   = 1'b1;
                    rd_addr = step[AW-1:0];
                    n_state = ffha_pkg::ST_M_CHK;
                end
            end

            ffha_pkg::ST_M_CHK: begin
                if (rd_free) begin
                    // Absorb the neighbour and its header into the current block
                    wr_en   = 1'b1;
                    wr_data = {1'b1, merged};
                    n_cs    = merged;
                    n_free  = r_free + AW'(1);
                end
                if (step_end) begin
                    n_valid  = 1'b1;
                    n_status = ffha_pkg::STAT_FREED;
                    n_state  = ffha_pkg::ST_IDLE;
                end else if (rd_free) begin
                    n_nx    = step;
                    rd_en   = 1'b1;
                    rd_addr = step[AW-1:0];
                end else begin
                    // Neighbour in use: skip past it
                    n_g     = step;
                    n_state = ffha_pkg::ST_M_RD;
                end
            end

            default: begin
                n_state = ffha_pkg::ST_IDLE;
            end
        endcase
    end

    assign fb_w = FBW'(r_free) << ffha_pkg::GRAN_SHIFT;

    assign busy                  = (r_state != ffha_pkg::ST_IDLE);
    assign o_valid               = r_valid;
    assign o_result.status       = r_status;
    assign o_result.block_offset = r_boff;
    assign o_result.free_bytes   = (fb_w > FBW'({ffha_pkg::REQ_W{1'b1}})) ?
                                   {ffha_pkg::REQ_W{1'b1}} : fb_w[ffha_pkg::REQ_W-1:0];

    `FFHA_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    `FFHA_ASSERT_IMP(a_accept_progress, i_clk, i_rst_n, start && !busy, ##1 (busy || o_valid), "accepted item dropped")
    `FFHA_ASSERT_IMP(a_offset_alloc_only, i_clk, i_rst_n, o_valid && o_result.status != ffha_pkg::STAT_ALLOC, o_result.block_offset == '0, "offset without allocation")
    `FFHA_ASSERT(a_free_bound, i_clk, i_rst_n, CW'(r_free) < CW'(GRANULES), "free total beyond arena")
    `FFHA_ASSERT_IMP(a_merge_in_arena, i_clk, i_rst_n, r_state == ffha_pkg::ST_M_RD, CW'(r_g) < CW'(GRANULES), "merge walk outside arena")

endmodule

### tb/first_fit_heap_allocator_core_test.sv
// Self-checking testbench for the first-fit heap allocator core: directed and random
// allocate/free requests, each result checked against a behavioural heap model.
// Depends on ffha_pkg and first_fit_heap_allocator_core.
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_test;

    localparam int unsigned ARENA       = ffha_pkg::ARENA_BYTES_DEF;
    localparam int unsigned GRAN        = ffha_pkg::GRAN_BYTES;
    localparam int unsigned GRANULES    = ARENA / GRAN;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int unsigned TAIL_CYCLES = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    ffha_pkg::t_in_item   i_item = '0;
    logic                 o_valid;
    ffha_pkg::t_out_item  o_result;

    // Heap model state: one header per granule, only block starts meaningful
    int unsigned blk_bytes [GRANULES];
    bit          hdr_free [GRANULES];
    int unsigned free_sum;

    ffha_pkg::t_out_item awaited_outcomes[$];
    logic [15:0] live_blocks[$];
    logic [15:0] last_released = 16'd8;
    bit          steady_phase = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned peak_live = 0;
    int unsigned status_tally [6];

    first_fit_heap_allocator_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_outcomes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void heap_reset();
        for (int unsigned i = 0; i < GRANULES; i++) begin
            blk_bytes[i] = 0;
            hdr_free[i] = 1'b0;
        end
        blk_bytes[0] = ARENA - GRAN;
        hdr_free[0] = 1'b1;
        free_sum    = ARENA - GRAN;
    endfunction

    function automatic int unsigned next_block(input int unsigned g);
        return g + 1 + blk_bytes[g] / GRAN;
    endfunction

    // Fold every run of adjacent free blocks into its first block
    function automatic void coalesce_free();
        int unsigned g;
        int unsigned nx;
        g = 0;
        while (g < GRANULES) begin
            nx = next_block(g);
            if (hdr_free[g] && nx < GRANULES && hdr_free[nx]) begin
                blk_bytes[g] += GRAN + blk_bytes[nx];
                free_sum     += GRAN;
            end else begin
                g = nx;
            end
        end
    endfunction

    function automatic ffha_pkg::t_out_item heap_outcome(input ffha_pkg::t_in_item it);
        ffha_pkg::t_out_item r;
        int unsigned sz;
        int unsigned g;
        int unsigned bs;
        int unsigned target;
        bit          placed;
        r.status       = ffha_pkg::STAT_NOSPACE;
        r.block_offset = '0;
        if (it.kind == ffha_pkg::KIND_ALLOC) begin
            if (it.request_size == 0) begin
                r.status = ffha_pkg::STAT_ZERO;
            end else begin
                sz     = ((32'(it.request_size) + GRAN - 1) / GRAN) * GRAN;
                g      = 0;
                placed = 1'b0;
                while (!placed && g < GRANULES) begin
                    bs = blk_bytes[g];
                    if (hdr_free[g] && bs >= sz) begin
                        // split only when a usable free block remains
                        if (bs >= sz + 2 * GRAN) begin
                            blk_bytes[g + 1 + sz / GRAN] = bs - sz - GRAN;
                            hdr_free[g + 1 + sz / GRAN] = 1'b1;
                            blk_bytes[g] = sz;
                            free_sum -= sz + GRAN;
                        end else begin
                            free_sum -= bs;
                        end
                        hdr_free[g]    = 1'b0;
                        r.status       = ffha_pkg::STAT_ALLOC;
                        r.block_offset = 16'((g + 1) * GRAN);
                        placed         = 1'b1;
                    end else begin
                        g = next_block(g);
                    end
                end
            end
        end else if (it.payload_offset == 0) begin
            r.status = ffha_pkg::STAT_NULL;
        end else if (it.payload_offset % GRAN != 0 || it.payload_offset < GRAN) begin
            r.status = ffha_pkg::STAT_REJECT;
        end else begin
            target = it.payload_offset / GRAN - 1;
            g = 0;
            while (g < GRANULES && g < target) g = next_block(g);
            if (g != target || g >= GRANULES || hdr_free[g]) begin
                r.status = ffha_pkg::STAT_REJECT;
            end else begin
                hdr_free[g] = 1'b1;
                free_sum   += blk_bytes[g];
                coalesce_free();
                r.status = ffha_pkg::STAT_FREED;
            end
        end
        r.free_bytes = (free_sum > 32'hFFFF) ? 16'hFFFF : 16'(free_sum);
        return r;
    endfunction

    function automatic ffha_pkg::t_in_item alloc_req(input logic [15:0] size);
        ffha_pkg::t_in_item it;
        it.kind           = ffha_pkg::KIND_ALLOC;
        it.request_size   = size;
        it.payload_offset = 16'($urandom);
        return it;
    endfunction

    function automatic ffha_pkg::t_in_item free_req(input logic [15:0] offset);
        ffha_pkg::t_in_item it;
        it.kind           = ffha_pkg::KIND_FREE;
        it.request_size   = 16'($urandom);
        it.payload_offset = offset;
        return it;
    endfunction

    // Drive one request, wait for acceptance, record what the heap should answer
    task automatic issue_request(input ffha_pkg::t_in_item it);
        ffha_pkg::t_out_item predicted;
        @(negedge i_clk);
        while (!steady_phase && $urandom_range(0, 99) < 12) @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = heap_outcome(it);
        awaited_outcomes.push_back(predicted);
        requests_sent++;
        status_tally[predicted.status]++;
        if (predicted.status == ffha_pkg::STAT_ALLOC) begin
            live_blocks.push_back(predicted.block_offset);
            if (live_blocks.size() > peak_live) peak_live = live_blocks.size();
        end else if (predicted.status == ffha_pkg::STAT_FREED) begin
            last_released = it.payload_offset;
            for (int i = 0; i < live_blocks.size(); i++) begin
                if (live_blocks[i] == it.payload_offset) begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
        // drop start so a stale item is never taken twice
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        ffha_pkg::t_out_item want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d offset %0d free %0d",
                         $time, o_result.status, o_result.block_offset, o_result.free_bytes);
                mismatch_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_result.status);
                    mismatch_count++;
                end
                if (o_result.block_offset !== want.block_offset) begin
                    $display("%0t: block_offset expected %0d, got %0d",
                             $time, want.block_offset, o_result.block_offset);
                    mismatch_count++;
                end
                if (o_result.free_bytes !== want.free_bytes) begin
                    $display("%0t: free_bytes expected %0d, got %0d",
                             $time, want.free_bytes, o_result.free_bytes);
                    mismatch_count++;
                end
            end
        end
    end

    // Zero size, oversize with rounding overflow, exact fit of the whole arena
    task automatic test_size_limits();
        issue_request(alloc_req(16'd0));
        issue_request(alloc_req(16'hFFFF));
        issue_request(alloc_req(16'(ARENA - GRAN)));
        issue_request(alloc_req(16'd1));
        issue_request(free_req(16'd8));
        issue_request(alloc_req(16'(ARENA - GRAN - 7)));
        issue_request(free_req(16'd8));
    endtask

    task automatic test_bad_frees();
        issue_request(free_req(16'd0));
        issue_request(free_req(16'd8));
        issue_request(free_req(16'd4));
        issue_request(free_req(16'd12));
        issue_request(free_req(16'(ARENA - GRAN)));
        issue_request(free_req(16'hFFFF));
    endtask

    task automatic test_split_and_merge();
        issue_request(alloc_req(16'd1));
        issue_request(alloc_req(16'd9));
        issue_request(alloc_req(16'd100));
        // inside the second block's payload, not a block start
        issue_request(free_req(16'd32));
        issue_request(free_req(16'd24));
        issue_request(free_req(16'd8));
        // leaves only 8 spare bytes, so no split
        issue_request(alloc_req(16'd24));
        issue_request(alloc_req(16'd8));
        issue_request(free_req(16'd48));
        issue_request(free_req(16'd8));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        ffha_pkg::t_in_item it;
        int unsigned pick;
        int unsigned tier;
        logic [15:0] size;
        for (int unsigned n = 0; n < count; n++) begin
            steady_phase = (n >= 200 && n < 320);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                case ($urandom_range(0, 3))
                    0: it = free_req(16'($urandom));
                    1: it = free_req(live_blocks.size() != 0 ?
                                     live_blocks[$urandom_range(0, live_blocks.size() - 1)] +
                                     16'($urandom_range(1, 15)) : 16'($urandom));
                    2: it = free_req(last_released);
                    default: it = ($urandom_range(0, 1) != 0) ? alloc_req(16'd0)
                                                               : free_req(16'd0);
                endcase
            end else if (live_blocks.size() != 0 &&
                         pick < (live_blocks.size() > 40 ? 75 : 45)) begin
                it = free_req(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end else begin
                tier = $urandom_range(0, 99);
                if (tier < 70)      size = 16'($urandom_range(1, 64));
                else if (tier < 90) size = 16'($urandom_range(65, 1024));
                else if (tier < 95) size = 16'($urandom_range(1025, 16383));
                else                size = 16'($urandom);
                it = alloc_req(size);
            end
            issue_request(it);
        end
        steady_phase = 1'b0;
    endtask

    initial begin
        heap_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_size_limits();
        test_bad_frees();
        test_split_and_merge();
        test_random_traffic(530);

        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d allocated, %0d freed, %0d out of space",
                 requests_sent, status_tally[ffha_pkg::STAT_ALLOC],
                 status_tally[ffha_pkg::STAT_FREED], status_tally[ffha_pkg::STAT_NOSPACE]);
        $display("%0d zero-size, %0d null, %0d rejected frees; up to %0d blocks held",
                 status_tally[ffha_pkg::STAT_ZERO], status_tally[ffha_pkg::STAT_NULL],
                 status_tally[ffha_pkg::STAT_REJECT], peak_live);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
